// File: hdl/fur_pkg.sv
package fur_pkg;

    localparam int BATCH_PACKETS = 16;
    // The packet size must be a power of two, because the packet count is formed by a shift.
    localparam int PACKET_BYTES  = 16;
    localparam int PKT_SHIFT     = $clog2(PACKET_BYTES);
    localparam int BP_W          = $clog2(BATCH_PACKETS + 1);
    localparam int BB_W          = $clog2(BATCH_PACKETS * PACKET_BYTES + 1);
    localparam int PT_W          = 28;
    localparam int MAX_SIZE_W    = 21;
    localparam int ADDR_W        = 24;
    localparam int PLEN_W        = 9;
    localparam int OFFSET_W      = 8;
    localparam int FUNC_W        = 3;
    localparam int CODE_W        = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 24;
    localparam int QUEUE_DEPTH   = 4;
    localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W     = 144;
    localparam int M_TDATA_W     = 80;

    localparam logic [MAX_SIZE_W-1:0] MAX_IMAGE_SIZE_RESET = MAX_SIZE_W'(1048576);
    localparam logic [ADDR_W-1:0]     STAGING_BASE_RESET   = '0;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IMAGE_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGING_BASE   = 1'd1;

    localparam logic [FUNC_W-1:0] FUNC_START     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_END       = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ABORT     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_VERSION   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_MALFORMED = 3'd5;

    typedef enum logic [2:0] {
        OP_START,
        OP_DATA,
        OP_MALFORMED,
        OP_END,
        OP_ABORT,
        OP_VERSION,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RECEIVING = 2'd1,
        PH_ERROR     = 2'd2,
        PH_COMPLETE  = 2'd3
    } phase_t;

    typedef enum logic [CODE_W-1:0] {
        RESP_SILENT        = 4'd0,
        RESP_SIZE_INVALID  = 4'd1,
        RESP_READY         = 4'd2,
        RESP_NOT_READY     = 4'd3,
        RESP_FORMAT        = 4'd4,
        RESP_NAK           = 4'd5,
        RESP_RESEND        = 4'd6,
        RESP_ACK           = 4'd7,
        RESP_NOT_RECEIVING = 4'd8,
        RESP_SIZE_MISMATCH = 4'd9,
        RESP_CRC_FAIL      = 4'd10,
        RESP_OK            = 4'd11,
        RESP_ABORTED       = 4'd12,
        RESP_VERSION       = 4'd13
    } resp_code_t;

    typedef struct packed {
        op_t               op;
        logic              size_bad;
        logic              plen_bad;
        logic [31:0]       image_size;
        logic [31:0]       announced_crc;
        logic [31:0]       seq;
        logic [PLEN_W-1:0] plen;
        logic [31:0]       computed_crc;
        logic [PT_W-1:0]   packet_total;
    } cmd_t;

    typedef struct packed {
        resp_code_t          code;
        logic [31:0]         value;
        logic [OFFSET_W-1:0] offset;
        logic                flush;
        logic [ADDR_W-1:0]   faddr;
        logic [PLEN_W-1:0]   flen;
        logic                erase;
        logic                commit;
    } resp_t;

endpackage

// File: hdl/fur_front.sv
module fur_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fur_pkg::FUNC_W-1:0]        func,
    input  logic [31:0]                       image_size,
    input  logic [31:0]                       announced_crc,
    input  logic [31:0]                       seq,
    input  logic [fur_pkg::PLEN_W-1:0]        payload_length,
    input  logic [31:0]                       computed_crc,
    input  logic [fur_pkg::MAX_SIZE_W-1:0]    max_image_size,
    input  logic                              queue_full,
    output logic                              push,
    output fur_pkg::cmd_t                     cmd
);
    import fur_pkg::*;

    logic [32:0] size_round;
    logic [32:0] size_div;

    assign s_ready    = !queue_full;
    assign push       = s_valid && !queue_full;
    assign size_round = {1'b0, image_size} + 33'(PACKET_BYTES - 1);
    assign size_div   = size_round >> PKT_SHIFT;

    always_comb begin
        cmd.image_size    = image_size;
        cmd.announced_crc = announced_crc;
        cmd.seq           = seq;
        cmd.plen          = payload_length;
        cmd.computed_crc  = computed_crc;
        cmd.packet_total  = size_div[PT_W-1:0];
        cmd.size_bad      = (image_size == 32'd0) || (image_size > 32'(max_image_size));
        cmd.plen_bad      = (payload_length == '0) ||
                            (payload_length > PLEN_W'(PACKET_BYTES));
        unique case (func)
            FUNC_START:     cmd.op = OP_START;
            FUNC_DATA:      cmd.op = OP_DATA;
            FUNC_END:       cmd.op = OP_END;
            FUNC_ABORT:     cmd.op = OP_ABORT;
            FUNC_VERSION:   cmd.op = OP_VERSION;
            FUNC_MALFORMED: cmd.op = OP_MALFORMED;
            default:        cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: hdl/fur_queue.sv
module fur_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  fur_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          q_valid,
    input  logic          pop,
    output fur_pkg::cmd_t pop_cmd
);
    import fur_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("Command queue count exceeds its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("Command queue popped while empty.");

endmodule

// File: hdl/fur_back.sv
module fur_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  fur_pkg::cmd_t                 cmd,
    output logic                          q_pop,
    input  logic [fur_pkg::ADDR_W-1:0]    staging_base,
    input  logic [fur_pkg::MAX_SIZE_W-1:0] max_image_size,
    output logic                          m_valid,
    input  logic                          m_ready,
    output fur_pkg::resp_t                resp
);
    import fur_pkg::*;

    phase_t          phase_reg, phase_next;
    logic [31:0]     total_reg, total_next;
    logic [31:0]     received_reg, received_next;
    logic [31:0]     exp_crc_reg, exp_crc_next;
    logic [31:0]     last_seq_reg, last_seq_next;
    logic [31:0]     written_reg, written_next;
    logic [PT_W-1:0] packet_total_reg, packet_total_next;
    logic [BP_W-1:0] batch_packets_reg, batch_packets_next;
    logic [BB_W-1:0] batch_bytes_reg, batch_bytes_next;
    logic            m_valid_reg;
    resp_t           resp_reg, resp_next;

    logic [BB_W-1:0] bb_eff;
    logic [BB_W-1:0] bb_sum;
    logic [BP_W-1:0] bp_inc;
    logic [31:0]     expect_seq;
    logic            last_pkt;
    logic            batch_full;

    assign q_pop   = q_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign resp    = resp_reg;

    always_comb begin
        bb_eff     = (batch_packets_reg == '0) ? '0 : batch_bytes_reg;
        bb_sum     = bb_eff + BB_W'(cmd.plen);
        bp_inc     = batch_packets_reg + 1'b1;
        expect_seq = (last_seq_reg == 32'd0 && received_reg == 32'd0) ?
                     32'd0 : last_seq_reg + 32'd1;
        last_pkt   = (cmd.seq == 32'(packet_total_reg) - 32'd1);
        batch_full = (bp_inc >= BP_W'(BATCH_PACKETS));
    end

    always_comb begin
        phase_next         = phase_reg;
        total_next         = total_reg;
        received_next      = received_reg;
        exp_crc_next       = exp_crc_reg;
        last_seq_next      = last_seq_reg;
        written_next       = written_reg;
        packet_total_next  = packet_total_reg;
        batch_packets_next = batch_packets_reg;
        batch_bytes_next   = batch_bytes_reg;
        resp_next          = '0;
        resp_next.code     = RESP_SILENT;
        if (q_pop) begin
            unique case (cmd.op)
                OP_START: begin
                    if (cmd.size_bad) begin
                        resp_next.code  = RESP_SIZE_INVALID;
                        resp_next.value = 32'(max_image_size);
                    end else begin
                        resp_next.code     = RESP_READY;
                        resp_next.erase    = 1'b1;
                        phase_next         = PH_RECEIVING;
                        total_next         = cmd.image_size;
                        received_next      = '0;
                        exp_crc_next       = cmd.announced_crc;
                        last_seq_next      = '0;
                        written_next       = '0;
                        packet_total_next  = cmd.packet_total;
                        batch_packets_next = '0;
                        batch_bytes_next   = '0;
                    end
                end
                OP_DATA: begin
                    if (phase_reg != PH_RECEIVING) begin
                        resp_next.code = RESP_NOT_READY;
                    end else if (cmd.plen_bad) begin
                        resp_next.code  = RESP_NAK;
                        resp_next.value = cmd.seq;
                    end else if (cmd.seq != expect_seq) begin
                        if (cmd.seq > expect_seq) begin
                            resp_next.code  = RESP_RESEND;
                            resp_next.value = expect_seq;
                        end
                    end else begin
                        resp_next.offset = bb_eff[OFFSET_W-1:0];
                        received_next    = received_reg + 32'(cmd.plen);
                        last_seq_next    = cmd.seq;
                        if (batch_full || last_pkt) begin
                            resp_next.code     = RESP_ACK;
                            resp_next.value    = cmd.seq;
                            resp_next.flush    = 1'b1;
                            resp_next.faddr    = staging_base + written_reg[ADDR_W-1:0];
                            resp_next.flen     = bb_sum[PLEN_W-1:0];
                            written_next       = written_reg + 32'(bb_sum);
                            batch_packets_next = '0;
                            batch_bytes_next   = '0;
                        end else begin
                            batch_packets_next = bp_inc;
                            batch_bytes_next   = bb_sum;
                        end
                    end
                end
                OP_MALFORMED: begin
                    resp_next.code = (phase_reg != PH_RECEIVING) ? RESP_NOT_READY : RESP_FORMAT;
                end
                OP_END: begin
                    if (phase_reg != PH_RECEIVING) begin
                        resp_next.code = RESP_NOT_RECEIVING;
                    end else if (received_reg != total_reg) begin
                        resp_next.code  = RESP_SIZE_MISMATCH;
                        resp_next.value = received_reg;
                        phase_next      = PH_ERROR;
                    end else if (cmd.computed_crc != exp_crc_reg) begin
                        resp_next.code  = RESP_CRC_FAIL;
                        resp_next.value = cmd.computed_crc;
                        phase_next      = PH_ERROR;
                    end else begin
                        resp_next.code   = RESP_OK;
                        resp_next.commit = 1'b1;
                        phase_next       = PH_COMPLETE;
                    end
                end
                OP_ABORT: begin
                    resp_next.code = RESP_ABORTED;
                    phase_next     = PH_IDLE;
                    received_next  = '0;
                    written_next   = '0;
                end
                OP_VERSION: begin
                    resp_next.code = RESP_VERSION;
                end
                default: begin
                    resp_next.code = RESP_SILENT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            total_reg         <= '0;
            received_reg      <= '0;
            exp_crc_reg       <= '0;
            last_seq_reg      <= '0;
            written_reg       <= '0;
            packet_total_reg  <= '0;
            batch_packets_reg <= '0;
            batch_bytes_reg   <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            total_reg         <= total_next;
            received_reg      <= received_next;
            exp_crc_reg       <= exp_crc_next;
            last_seq_reg      <= last_seq_next;
            written_reg       <= written_next;
            packet_total_reg  <= packet_total_next;
            batch_packets_reg <= batch_packets_next;
            batch_bytes_reg   <= batch_bytes_next;
            if (q_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            resp_reg <= resp_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        batch_packets_reg < BP_W'(BATCH_PACKETS))
        else $error("Batch packet count reached a full batch without a flush.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && resp_reg.flush |-> resp_reg.code == RESP_ACK)
        else $error("Flush issued without an acknowledge response.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && resp_next.flush |=> batch_packets_reg == '0)
        else $error("Batch counters not cleared after a flush.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && resp_next.commit |=> phase_reg == PH_COMPLETE)
        else $error("Commit issued without entering the complete phase.");

endmodule

// File: hdl/firmware_update_receiver.sv
// A command accepted on the s_ side is written into the command queue, then popped into
// the back result register, which presents it on the m_ side. Throughput: one command
// per cycle unless the queue is full; the back retires one per cycle unless m_ stalls.
// The four-entry command queue lets input and output stall independently.
// Reset (synchronous, aresetn low) empties the queue and the output register, sets
// the phase to idle, clears all counters and restores both configuration registers.
module firmware_update_receiver (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fur_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fur_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // Fields from bit 0: image_size, announced_crc, seq, payload_length, computed_crc.
    input  logic [fur_pkg::S_TDATA_W-1:0]         s_tdata,
    // Fields from bit 0: func.
    input  logic [fur_pkg::FUNC_W-1:0]            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // Fields from bit 0: response_value, buffer_offset, flush, flush_address,
    // flush_length, erase_staging, commit.
    output logic [fur_pkg::M_TDATA_W-1:0]         m_tdata,
    // Fields from bit 0: response_code.
    output logic [fur_pkg::CODE_W-1:0]            m_tuser
);
    import fur_pkg::*;

    logic [MAX_SIZE_W-1:0] max_size_reg;
    logic [ADDR_W-1:0]     staging_base_reg;
    logic                  queue_full;
    logic                  push;
    cmd_t                  push_cmd;
    logic                  q_valid;
    logic                  q_pop;
    cmd_t                  pop_cmd;
    resp_t                 resp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg     <= MAX_IMAGE_SIZE_RESET;
            staging_base_reg <= STAGING_BASE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_IMAGE_SIZE: max_size_reg     <= cfg_data[MAX_SIZE_W-1:0];
                CFG_STAGING_BASE:   staging_base_reg <= cfg_data[ADDR_W-1:0];
                default:            max_size_reg     <= max_size_reg;
            endcase
        end
    end

    fur_front u_front (
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .func           (s_tuser),
        .image_size     (s_tdata[31:0]),
        .announced_crc  (s_tdata[63:32]),
        .seq            (s_tdata[95:64]),
        .payload_length (s_tdata[104:96]),
        .computed_crc   (s_tdata[136:105]),
        .max_image_size (max_size_reg),
        .queue_full     (queue_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    fur_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .q_valid  (q_valid),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd)
    );

    fur_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .cmd            (pop_cmd),
        .q_pop          (q_pop),
        .staging_base   (staging_base_reg),
        .max_image_size (max_size_reg),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .resp           (resp)
    );

    assign m_tuser = resp.code;
    assign m_tdata = {4'b0, resp.commit, resp.erase, resp.flen, resp.faddr,
                      resp.flush, resp.offset, resp.value};

endmodule

// File: test/firmware_update_receiver_tb.sv
`timescale 1ns / 100ps

module firmware_update_receiver_tb;
    import fur_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_RESERVED_A = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_B = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [31:0]       image_size;
        logic [31:0]       announced_crc;
        logic [31:0]       seq;
        logic [PLEN_W-1:0] payload_length;
        logic [31:0]       computed_crc;
    } command_t;

    typedef struct packed {
        resp_code_t          code;
        logic [31:0]         value;
        logic [OFFSET_W-1:0] offset;
        logic                flush;
        logic [ADDR_W-1:0]   faddr;
        logic [PLEN_W-1:0]   flen;
        logic                erase;
        logic                commit;
    } response_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [FUNC_W-1:0]     s_tuser   = '0;
    logic                  m_tready  = 1'b1;
    wire                   cfg_ready;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [M_TDATA_W-1:0]  m_tdata;
    wire  [CODE_W-1:0]     m_tuser;

    firmware_update_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the receiver state and its configuration.
    phase_t                rx_phase     = PH_IDLE;
    logic [31:0]           image_total  = '0;
    logic [31:0]           bytes_in     = '0;
    logic [31:0]           image_crc    = '0;
    logic [31:0]           prev_seq     = '0;
    logic [31:0]           staged_bytes = '0;
    logic [PT_W-1:0]       pkt_count    = '0;
    logic [BP_W-1:0]       batch_count  = '0;
    logic [BB_W-1:0]       batch_fill   = '0;
    logic [MAX_SIZE_W-1:0] max_size     = MAX_IMAGE_SIZE_RESET;
    logic [ADDR_W-1:0]     base_addr    = STAGING_BASE_RESET;

    command_t  pending_cmds[$];
    response_t expected_responses[$];
    command_t  taken_cmd;
    response_t due_response;
    int        fault_count   = 0;
    int        queued_items  = 0;
    int        accepted_cmds = 0;
    int        driven_cmds   = 0;
    int        burst_left    = 0;
    int        gap_left      = 0;
    int        stall_mode    = 0;
    int        stall_timer   = 0;
    logic [15:0] stall_pattern = '1;
    int        idle_cycles   = 0;

    function automatic response_t compute_response(command_t c);
        response_t r;
        logic [31:0] next_seq;
        logic [32:0] rounded;
        r = '0;
        case (c.func)
            FUNC_START: begin
                if (c.image_size == 32'd0 || c.image_size > 32'(max_size)) begin
                    r.code  = RESP_SIZE_INVALID;
                    r.value = 32'(max_size);
                end else begin
                    rounded      = {1'b0, c.image_size} + 33'(PACKET_BYTES - 1);
                    r.erase      = 1'b1;
                    r.code       = RESP_READY;
                    image_total  = c.image_size;
                    bytes_in     = '0;
                    image_crc    = c.announced_crc;
                    prev_seq     = '0;
                    staged_bytes = '0;
                    rx_phase     = PH_RECEIVING;
                    pkt_count    = PT_W'(rounded / 33'(PACKET_BYTES));
                    batch_count  = '0;
                    batch_fill   = '0;
                end
            end
            FUNC_DATA, FUNC_MALFORMED: begin
                if (rx_phase != PH_RECEIVING) begin
                    r.code = RESP_NOT_READY;
                end else if (c.func == FUNC_MALFORMED) begin
                    r.code = RESP_FORMAT;
                end else if (c.payload_length == '0 ||
                             c.payload_length > PLEN_W'(PACKET_BYTES)) begin
                    r.code  = RESP_NAK;
                    r.value = c.seq;
                end else begin
                    next_seq = (prev_seq == '0 && bytes_in == '0) ? 32'd0 : prev_seq + 32'd1;
                    if (c.seq > next_seq) begin
                        r.code  = RESP_RESEND;
                        r.value = next_seq;
                    end else if (c.seq == next_seq) begin
                        if (batch_count == '0) begin
                            batch_fill = '0;
                        end
                        r.offset    = OFFSET_W'(batch_fill);
                        batch_fill  = batch_fill + BB_W'(c.payload_length);
                        batch_count = batch_count + 1'b1;
                        bytes_in    = bytes_in + 32'(c.payload_length);
                        prev_seq    = c.seq;
                        if (batch_count >= BP_W'(BATCH_PACKETS) ||
                            c.seq == 32'(pkt_count) - 32'd1) begin
                            r.flush      = 1'b1;
                            r.faddr      = ADDR_W'(32'(base_addr) + staged_bytes);
                            r.flen       = PLEN_W'(batch_fill);
                            r.code       = RESP_ACK;
                            r.value      = c.seq;
                            staged_bytes = staged_bytes + 32'(batch_fill);
                            batch_count  = '0;
                            batch_fill   = '0;
                        end
                    end
                end
            end
            FUNC_END: begin
                if (rx_phase != PH_RECEIVING) begin
                    r.code = RESP_NOT_RECEIVING;
                end else if (bytes_in != image_total) begin
                    r.code   = RESP_SIZE_MISMATCH;
                    r.value  = bytes_in;
                    rx_phase = PH_ERROR;
                end else if (c.computed_crc != image_crc) begin
                    r.code   = RESP_CRC_FAIL;
                    r.value  = c.computed_crc;
                    rx_phase = PH_ERROR;
                end else begin
                    r.code   = RESP_OK;
                    r.commit = 1'b1;
                    rx_phase = PH_COMPLETE;
                end
            end
            FUNC_ABORT: begin
                rx_phase     = PH_IDLE;
                bytes_in     = '0;
                staged_bytes = '0;
                r.code       = RESP_ABORTED;
            end
            FUNC_VERSION: begin
                r.code = RESP_VERSION;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_command(command_t c);
        return S_TDATA_W'({c.computed_crc, c.payload_length, c.seq, c.announced_crc,
                           c.image_size});
    endfunction

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    task automatic add_cmd(input logic [FUNC_W-1:0] f, input logic [31:0] size,
                           input logic [31:0] crc, input logic [31:0] sq,
                           input logic [PLEN_W-1:0] pl, input logic [31:0] cc);
        command_t c;
        c.func           = f;
        c.image_size     = size;
        c.announced_crc  = crc;
        c.seq            = sq;
        c.payload_length = pl;
        c.computed_crc   = cc;
        pending_cmds.push_back(c);
        queued_items++;
    endtask

    task automatic add_noise(input logic [31:0] next_seq);
        logic [31:0] sq;
        logic [31:0] size;
        case ($urandom_range(0, 7))
            0: add_cmd(FUNC_DATA, $urandom, $urandom, next_seq - 32'd1,
                       PLEN_W'($urandom_range(1, PACKET_BYTES)), $urandom);
            1: begin
                sq = $urandom_range(0, 1) ? next_seq + 32'($urandom_range(1, 20)) : $urandom;
                add_cmd(FUNC_DATA, $urandom, $urandom, sq,
                        PLEN_W'($urandom_range(1, PACKET_BYTES)), $urandom);
            end
            2: add_cmd(FUNC_DATA, $urandom, $urandom, $urandom,
                       $urandom_range(0, 1) ? PLEN_W'(0) : PLEN_W'($urandom_range(17, 511)),
                       $urandom);
            3: add_cmd(FUNC_MALFORMED, $urandom, $urandom, $urandom, PLEN_W'($urandom),
                       $urandom);
            4: add_cmd(FUNC_VERSION, $urandom, $urandom, $urandom, PLEN_W'($urandom),
                       $urandom);
            5: add_cmd($urandom_range(0, 1) ? FUNC_RESERVED_A : FUNC_RESERVED_B, $urandom,
                       $urandom, $urandom, PLEN_W'($urandom), $urandom);
            6: begin
                case ($urandom_range(0, 2))
                    0: size = 32'd0;
                    1: size = 32'(max_size) + 32'($urandom_range(1, 1000));
                    default: size = $urandom | 32'h8000_0000;
                endcase
                add_cmd(FUNC_START, size, $urandom, $urandom, PLEN_W'($urandom), $urandom);
            end
            default: add_cmd(FUNC_W'($urandom_range(1, 7)), $urandom, $urandom, $urandom,
                             PLEN_W'($urandom), $urandom);
        endcase
    endtask

    // A start, image packets in order with occasional disturbances, maybe an end or abort.
    task automatic queue_session();
        int lim;
        int size;
        int npkt;
        int nsend;
        int r;
        logic [31:0] crc;
        logic [31:0] ccrc;
        logic [PLEN_W-1:0] plen;
        lim = int'(max_size);
        r = $urandom_range(0, 9);
        if (r < 6) begin
            size = $urandom_range(1, imin(lim, 256));
        end else if (r < 9) begin
            size = $urandom_range(1, imin(lim, 800));
        end else begin
            size = $urandom_range(1, lim);
        end
        crc   = $urandom;
        npkt  = (size + PACKET_BYTES - 1) / PACKET_BYTES;
        nsend = (npkt > 48) ? $urandom_range(8, 48) : npkt;
        add_cmd(FUNC_START, size, crc, $urandom, PLEN_W'($urandom), $urandom);
        for (int i = 0; i < nsend; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                add_noise(i);
            end
            if ($urandom_range(0, 99) < 2) begin
                add_cmd(FUNC_ABORT, $urandom, $urandom, $urandom, PLEN_W'($urandom), $urandom);
                return;
            end
            plen = (i == npkt - 1) ? PLEN_W'(size - PACKET_BYTES * (npkt - 1))
                                   : PLEN_W'(PACKET_BYTES);
            if ($urandom_range(0, 99) < 4) begin
                plen = PLEN_W'($urandom_range(1, PACKET_BYTES));
            end
            add_cmd(FUNC_DATA, $urandom, $urandom, i, plen, $urandom);
        end
        r = $urandom_range(0, 9);
        if (r == 0) begin
            ccrc = crc ^ (32'd1 << $urandom_range(0, 31));
        end else if (r == 1) begin
            ccrc = $urandom;
        end else begin
            ccrc = crc;
        end
        if (r != 2) begin
            add_cmd(FUNC_END, $urandom, $urandom, $urandom, PLEN_W'($urandom), ccrc);
        end
    endtask

    task automatic queue_directed();
        add_cmd(FUNC_VERSION, 32'd0, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_MALFORMED, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_END, 32'd0, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_START, 32'd0, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF,
                32'hFFFF_FFFF);
        add_cmd(FUNC_START, 32'd1048577, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_START, 32'd40, 32'hDEAD_BEEF, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_MALFORMED, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd17, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'hFFFF_FFFF, 9'd256, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'hFFFF_FFFF, 9'd16, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd1, 9'd16, 32'd0);
        add_cmd(FUNC_END, 32'd0, 32'd0, 32'd0, 9'd0, 32'hDEAD_BEEF);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd2, 9'd8, 32'd0);
        add_cmd(FUNC_RESERVED_A, 32'd5, 32'd5, 32'd5, 9'd5, 32'd5);
        add_cmd(FUNC_RESERVED_B, 32'd5, 32'd5, 32'd5, 9'd5, 32'd5);
        add_cmd(FUNC_START, 32'd1048576, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_ABORT, 32'd0, 32'd0, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_START, 32'd20, 32'h1234_5678, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd16, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd1, 9'd4, 32'd0);
        add_cmd(FUNC_END, 32'd0, 32'd0, 32'd0, 9'd0, 32'h1234_5679);
        add_cmd(FUNC_START, 32'd1, 32'hA5A5_5A5A, 32'd0, 9'd0, 32'd0);
        add_cmd(FUNC_DATA, 32'd0, 32'd0, 32'd0, 9'd1, 32'd0);
        add_cmd(FUNC_END, 32'd0, 32'd0, 32'd0, 9'd0, 32'hA5A5_5A5A);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int budget);
        int first;
        first = queued_items;
        while (queued_items - first < budget) begin
            if (max_size == '0 || $urandom_range(0, 9) == 0) begin
                add_noise($urandom);
            end else begin
                queue_session();
            end
        end
        drain();
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        if (idx == CFG_MAX_IMAGE_SIZE) begin
            max_size = data[MAX_SIZE_W-1:0];
        end else begin
            base_addr = data;
        end
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (!s_tvalid || accepted_cmds == driven_cmds) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (aresetn && pending_cmds.size() != 0) begin
                s_tdata  <= pack_command(pending_cmds[0]);
                s_tuser  <= pending_cmds[0].func;
                s_tvalid <= 1'b1;
                driven_cmds++;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                             : $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 6);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_mode    = $urandom_range(0, 2);
            stall_pattern = 16'($urandom);
            stall_timer   = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= stall_pattern[0];
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            taken_cmd = pending_cmds.pop_front();
            expected_responses.push_back(compute_response(taken_cmd));
            accepted_cmds++;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_responses.size() == 0) begin
                $error("response_code: expected none, actual %0d", m_tuser);
                fault_count++;
            end else begin
                due_response = expected_responses.pop_front();
                check_field("response_code", 32'(due_response.code), 32'(m_tuser));
                check_field("response_value", due_response.value, m_tdata[31:0]);
                check_field("buffer_offset", 32'(due_response.offset), 32'(m_tdata[39:32]));
                check_field("flush", 32'(due_response.flush), 32'(m_tdata[40]));
                check_field("flush_address", 32'(due_response.faddr), 32'(m_tdata[64:41]));
                check_field("flush_length", 32'(due_response.flen), 32'(m_tdata[73:65]));
                check_field("erase_staging", 32'(due_response.erase), 32'(m_tdata[74]));
                check_field("commit", 32'(due_response.commit), 32'(m_tdata[75]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        queue_directed();
        run_phase(180);

        write_register(CFG_MAX_IMAGE_SIZE, 24'd1);
        write_register(CFG_STAGING_BASE, 24'hFF_FFFF);
        run_phase(110);

        write_register(CFG_MAX_IMAGE_SIZE, 24'hFF_FFFF);
        write_register(CFG_STAGING_BASE, 24'hFF_FF00);
        run_phase(250);

        write_register(CFG_MAX_IMAGE_SIZE, 24'h20_0000);
        write_register(CFG_STAGING_BASE, 24'($urandom));
        run_phase(40);

        write_register(CFG_MAX_IMAGE_SIZE, 24'($urandom_range(100, 900)));
        write_register(CFG_STAGING_BASE, 24'($urandom));
        run_phase(200);

        write_register(CFG_MAX_IMAGE_SIZE, 24'd1048576);
        write_register(CFG_STAGING_BASE, 24'd0);
        run_phase(150);

        if (fault_count == 0 && expected_responses.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/fur_pkg.sv
hdl/fur_front.sv
hdl/fur_queue.sv
hdl/fur_back.sv
hdl/firmware_update_receiver.sv
test/firmware_update_receiver_tb.sv
